// ----- src/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(name, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// consequence that must hold in the cycle after the antecedent
`define ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/cdes_pkg.sv -----
`timescale 1ns / 1ps

package cdes_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int EPOCH_W = 38;
  localparam int DAYS_W  = 22;
  localparam int TOD_W   = 17;
  localparam int IN_W    = 40;
  localparam int OUT_W   = 40;

  localparam logic [YEAR_W-1:0]  FIRST_YEAR  = 14'd1970;
  localparam logic [YEAR_W-1:0]  LAST_YEAR   = 14'd9999;
  localparam logic [MONTH_W-1:0] LAST_MONTH  = 4'd12;
  // leap years in 1..1969
  localparam logic [DAYS_W-1:0]  LEAPS_AT_EPOCH = 22'd477;
  // floor(p / 100) == (p * 5243) >> 19 for every p below 43699
  localparam logic [12:0]        RECIP_100   = 13'd5243;
  localparam int                 RECIP_SHIFT = 19;
  localparam logic [TOD_W-1:0]   DAY_SECS    = 17'd86400;

  typedef struct packed {
    logic load;
    logic div;
    logic base;
    logic month_step;
    logic add_day;
    logic mul;
    logic emit;
  } cdes_cmd_t;

  typedef struct packed {
    logic month_done;
    logic out_free;
  } cdes_sts_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

// ----- src/cdes_ctrl.sv -----
`timescale 1ns / 1ps

module cdes_ctrl
  import cdes_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  cdes_sts_t sts,
  output cdes_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_BASE,
    ST_MONTH,
    ST_DAY,
    ST_MUL,
    ST_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div   = 1'b1;
        state_nxt = ST_BASE;
      end
      ST_BASE: begin
        cmd.base  = 1'b1;
        state_nxt = ST_MONTH;
      end
      ST_MONTH: begin
        if (sts.month_done) begin
          state_nxt = ST_DAY;
        end else begin
          cmd.month_step = 1'b1;
        end
      end
      ST_DAY: begin
        cmd.add_day = 1'b1;
        state_nxt   = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- src/cdes_dp.sv -----
`timescale 1ns / 1ps

module cdes_dp
  import cdes_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cdes_cmd_t        cmd,
  output cdes_sts_t        sts,
  input  logic [IN_W-1:0]  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] out_data,
  output logic             out_bad
);

  logic [YEAR_W-1:0]  year_r;
  logic [MONTH_W-1:0] month_r;
  logic [DAY_W-1:0]   day_r;
  logic [HOUR_W-1:0]  hour_r;
  logic [MIN_W-1:0]   min_r;
  logic [SEC_W-1:0]   sec_r;
  logic [7:0]         q_r;
  logic               leap_r;
  logic               bad_r;
  logic [MONTH_W-1:0] m_r;
  logic [DAYS_W-1:0]  days_r;
  logic [TOD_W-1:0]   tod_r;
  logic [EPOCH_W-1:0] prod_r;
  logic [EPOCH_W-1:0] epoch_r;
  logic               out_bad_r;
  logic               out_valid_r;

  logic [YEAR_W-1:0]  p_w;
  logic [26:0]        qprod_w;
  logic [YEAR_W-1:0]  rem_w;
  logic [7:0]         q1_w;
  logic               leap_w;
  logic [YEAR_W-1:0]  ydiff_w;
  logic [DAYS_W-1:0]  base_w;
  logic               range_bad_w;
  logic               day_bad_w;

  assign p_w     = year_r - 14'd1;
  assign qprod_w = 27'(p_w) * 27'(RECIP_100);
  // year is a multiple of 100 exactly when (year - 1) mod 100 is 99
  assign rem_w   = p_w - 14'(15'(q_r) * 15'd100);
  assign q1_w    = q_r + 8'd1;
  assign leap_w  = (rem_w == 14'd99) ? (q1_w[1:0] == 2'd0) : (year_r[1:0] == 2'd0);
  assign ydiff_w = year_r - FIRST_YEAR;
  assign base_w  = DAYS_W'(ydiff_w) * 22'd365 + DAYS_W'(p_w >> 2) - DAYS_W'(q_r)
                 + DAYS_W'(q_r >> 2) - LEAPS_AT_EPOCH;
  assign range_bad_w = (year_r < FIRST_YEAR) || (year_r > LAST_YEAR) ||
                       (month_r == 4'd0) || (month_r > LAST_MONTH);
  assign day_bad_w   = (day_r == 5'd0) || (day_r > month_len(month_r, leap_r));

  assign sts.month_done = bad_r || (m_r >= month_r);
  assign sts.out_free   = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      year_r  <= in_data[13:0];
      month_r <= in_data[17:14];
      day_r   <= in_data[22:18];
      hour_r  <= in_data[27:23];
      min_r   <= in_data[33:28];
      sec_r   <= in_data[39:34];
    end
    if (cmd.div) begin
      q_r <= qprod_w[RECIP_SHIFT +: 8];
    end
    if (cmd.base) begin
      leap_r <= leap_w;
      bad_r  <= range_bad_w;
      days_r <= base_w;
      m_r    <= 4'd1;
    end
    if (cmd.month_step) begin
      days_r <= days_r + DAYS_W'(month_len(m_r, leap_r));
      m_r    <= m_r + 4'd1;
    end
    if (cmd.add_day) begin
      bad_r  <= bad_r | day_bad_w;
      days_r <= days_r + DAYS_W'(day_r) - 22'd1;
      tod_r  <= TOD_W'(hour_r) * 17'd3600 + TOD_W'(min_r) * 17'd60 + TOD_W'(sec_r);
    end
    if (cmd.mul) begin
      prod_r <= EPOCH_W'(days_r) * EPOCH_W'(DAY_SECS);
    end
    if (cmd.emit) begin
      epoch_r   <= bad_r ? '0 : prod_r + EPOCH_W'(tod_r);
      out_bad_r <= bad_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = {{(OUT_W-EPOCH_W){1'b0}}, epoch_r};
  assign out_bad   = out_bad_r;

endmodule

// ----- src/civil_date_to_epoch_seconds.sv -----
`timescale 1ns / 1ps
// channel   direction  tdata (low bit up)                            tuser
// in_*      slave      year 14, month 4, day 5, hour 5, min 6, sec 6  -
// out_*     master     epoch_seconds 38, zero pad 2                   bad_input
//
// one item at a time: each input steps through divide, base, a step per month
// before the given month, day, multiply and emit; a bad year or month skips the months
// the result sits in an output register, so the next item is taken while it waits
// a stalled result holds the sequencer in its final step until the slot frees
// rst_n is synchronous and active low; it clears the sequencer and the output valid
`include "assert_macros.svh"

module civil_date_to_epoch_seconds
  import cdes_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // year, month, day, hour, minute, second
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // epoch_seconds, zero pad
  output logic             out_tuser   // bad_input
);

  cdes_cmd_t cmd;
  cdes_sts_t sts;

  cdes_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cdes_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_tdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_bad   (out_tuser)
  );

  // not ready right after a transfer
  `ASSERT_NEXT(a_busy_after_load, in_tvalid && in_tready, !in_tready)
  // a flagged result carries zero seconds
  `ASSERT_ALWAYS(a_bad_is_zero, !(out_tvalid && out_tuser) || (out_tdata == '0))
  // a result is only written into a free output slot
  `ASSERT_ALWAYS(a_emit_free, !cmd.emit || sts.out_free)
  // at most one step command at a time
  `ASSERT_ALWAYS(a_cmd_onehot, $onehot0(cmd))

endmodule

// ----- tb/sv/tb_civil_date_to_epoch_seconds.sv -----
`timescale 1ns / 1ps

module tb_civil_date_to_epoch_seconds
  import cdes_pkg::*;
();

  localparam int RANDOM_ITEMS       = 780;
  localparam int CYCLE_LIMIT        = 1000000;
  localparam int SETTLE_CYCLES      = 50;
  localparam int HOLDOFF_AFTER      = 400;
  localparam int HOLDOFF_CYCLES     = 400;
  localparam int LEAPS_BEFORE_EPOCH = 477;  // leap years in 1..1969
  localparam int HOUR_SECS          = 3600;
  localparam int MINUTE_SECS        = 60;
  localparam int N_DIRECTED         = 23;

  typedef struct packed {
    logic [EPOCH_W-1:0] seconds;
    logic               bad;
  } epoch_result_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
    logic               known;
    logic [EPOCH_W-1:0] seconds;
    logic               bad;
  } date_case_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tuser;

  // expectation typed into the table, travels alongside in_tdata
  logic          typed_known = 1'b0;
  epoch_result_t typed_result = '0;

  epoch_result_t pending_epochs[$];
  epoch_result_t want_result;
  int            mismatches = 0;
  int            results_seen = 0;
  int            cycle_count = 0;

  date_case_t directed_cases [N_DIRECTED] = '{
    '{1970,  1,  1,  0,  0,  0, 1, 0,                  0},
    '{9999, 12, 31, 23, 59, 59, 1, 38'd253402300799,   0},
    '{2038,  1, 19,  3, 14,  7, 1, 2147483647,         0},
    '{2000,  3,  1,  0,  0,  0, 1, 951868800,          0},
    '{1969, 12, 31, 23, 59, 59, 1, 0,                  1},
    '{10000, 1,  1,  0,  0,  0, 1, 0,                  1},
    '{0,     0,  0,  0,  0,  0, 1, 0,                  1},
    '{16383, 15, 31, 31, 63, 63, 1, 0,                 1},
    '{2000,  0,  1,  0,  0,  0, 1, 0,                  1},
    '{2000, 13,  1,  0,  0,  0, 1, 0,                  1},
    '{2000, 15,  1,  0,  0,  0, 1, 0,                  1},
    '{2000,  6,  0,  0,  0,  0, 1, 0,                  1},
    '{2001,  4, 31,  0,  0,  0, 1, 0,                  1},
    '{2100,  2, 29,  0,  0,  0, 1, 0,                  1},
    '{2001,  2, 29,  0,  0,  0, 1, 0,                  1},
    '{2000,  2, 30,  0,  0,  0, 1, 0,                  1},
    '{2000,  2, 29, 12,  0,  0, 0, 0,                  0},
    '{2024,  2, 29,  0,  0,  0, 0, 0,                  0},
    '{1970,  1,  1, 31, 63, 63, 0, 0,                  0},
    '{9999, 12, 31, 31, 63, 63, 0, 0,                  0},
    '{1970, 12, 31, 23, 59, 59, 0, 0,                  0},
    '{2023,  1, 31,  7, 30, 15, 0, 0,                  0},
    '{9999,  1,  1,  0,  0,  0, 0, 0,                  0}
  };

  civil_date_to_epoch_seconds dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic int days_in_month(logic [MONTH_W-1:0] m, logic [YEAR_W-1:0] y);
    logic leap;
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    case (m)
      4'd2: begin
        return leap ? 29 : 28;
      end
      4'd4, 4'd6, 4'd9, 4'd11: begin
        return 30;
      end
      default: begin
        return (m >= 1 && m <= LAST_MONTH) ? 31 : 0;
      end
    endcase
  endfunction

  function automatic logic [IN_W-1:0] pack_date(logic [YEAR_W-1:0] y, logic [MONTH_W-1:0] mo,
                                                logic [DAY_W-1:0] d, logic [HOUR_W-1:0] h,
                                                logic [MIN_W-1:0] mi, logic [SEC_W-1:0] s);
    return {s, mi, h, d, mo, y};
  endfunction

  function automatic epoch_result_t predict_epoch(logic [IN_W-1:0] word);
    logic [YEAR_W-1:0]  y;
    logic [MONTH_W-1:0] mo;
    logic [DAY_W-1:0]   d;
    logic [HOUR_W-1:0]  h;
    logic [MIN_W-1:0]   mi;
    logic [SEC_W-1:0]   s;
    longint unsigned    days;
    longint unsigned    prior;
    epoch_result_t      res;
    {s, mi, h, d, mo, y} = word;
    res.seconds = '0;
    res.bad     = 1'b1;
    if (y >= FIRST_YEAR && y <= LAST_YEAR && mo >= 1 && mo <= LAST_MONTH &&
        d >= 1 && d <= days_in_month(mo, y)) begin
      prior = longint'(y) - 1;
      days  = 365 * (longint'(y) - longint'(FIRST_YEAR))
            + prior / 4 - prior / 100 + prior / 400 - LEAPS_BEFORE_EPOCH;
      for (int k = 1; k < mo; k++) days += days_in_month(k[MONTH_W-1:0], y);
      days += longint'(d) - 1;
      res.seconds = EPOCH_W'(days * DAY_SECS + longint'(h) * HOUR_SECS
                             + longint'(mi) * MINUTE_SECS + longint'(s));
      res.bad     = 1'b0;
    end
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // one item offered until its transfer; returns at the transfer edge with valid still high
  task automatic offer_date(input logic [IN_W-1:0] word, input logic known,
                            input epoch_result_t typed, input bit calm);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid    <= 1'b1;
    in_tdata     <= word;
    typed_known  <= known;
    typed_result <= typed;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain_epochs();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_epochs.size() != 0);
  endtask

  // scoreboard: results checked first, then the new transfer queued
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_epochs.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result seconds %0d bad %0b", $time,
                   out_tdata[EPOCH_W-1:0], out_tuser);
        end else begin
          want_result = pending_epochs.pop_front();
          results_seen++;
          if (out_tdata[EPOCH_W-1:0] !== want_result.seconds) begin
            mismatches++;
            $display("%0t: epoch_seconds expected %0d, actual %0d", $time,
                     want_result.seconds, out_tdata[EPOCH_W-1:0]);
          end
          if (out_tuser !== want_result.bad) begin
            mismatches++;
            $display("%0t: bad_input expected %0b, actual %0b", $time,
                     want_result.bad, out_tuser);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        pending_epochs.push_back(typed_known ? typed_result : predict_epoch(in_tdata));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: random stalls, calm stretches, one long hold-off
  initial begin : result_sink
    int  span;
    int  r;
    bit  ready;
    bit  held;
    held = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (!held && results_seen >= HOLDOFF_AFTER) begin
        held  = 1'b1;
        ready = 1'b0;
        span  = HOLDOFF_CYCLES;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          ready = 1'b1;
          span  = $urandom_range(1, 8);
        end else if (r < 70) begin
          ready = 1'b1;
          span  = $urandom_range(20, 60);
        end else if (r < 93) begin
          ready = 1'b0;
          span  = $urandom_range(1, 3);
        end else begin
          ready = 1'b0;
          span  = $urandom_range(15, 50);
        end
      end
      out_tready <= ready;
      repeat (span) @(posedge clk);
    end
  end

  initial begin : date_source
    logic [YEAR_W-1:0]  y;
    logic [MONTH_W-1:0] mo;
    logic [DAY_W-1:0]   d;
    logic [HOUR_W-1:0]  h;
    logic [MIN_W-1:0]   mi;
    logic [SEC_W-1:0]   s;
    logic [IN_W-1:0]    word;
    epoch_result_t      typed;
    int                 r;
    do @(posedge clk); while (!rst_n);

    foreach (directed_cases[i]) begin
      typed.seconds = directed_cases[i].seconds;
      typed.bad     = directed_cases[i].bad;
      offer_date(pack_date(directed_cases[i].year, directed_cases[i].month,
                           directed_cases[i].day, directed_cases[i].hour,
                           directed_cases[i].minute, directed_cases[i].second),
                 directed_cases[i].known, typed, 1'b0);
    end
    // sender waits for every result before the random part
    drain_epochs();

    typed = '0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          case ($urandom_range(0, 5))
            0: y = FIRST_YEAR;
            1: y = LAST_YEAR;
            2: y = FIRST_YEAR - 14'd1;
            3: y = LAST_YEAR + 14'd1;
            4: y = 14'd2000;
            default: y = 14'd2100;
          endcase
        end else if (r < 40) begin
          y = YEAR_W'($urandom_range(FIRST_YEAR, 2100));
        end else begin
          y = YEAR_W'($urandom_range(FIRST_YEAR, LAST_YEAR));
        end
        mo = MONTH_W'($urandom_range(1, LAST_MONTH));
        d  = (days_in_month(mo, y) > 0) ?
             DAY_W'($urandom_range(1, days_in_month(mo, y))) : 5'd1;
        if ($urandom_range(0, 99) < 85) begin
          h  = HOUR_W'($urandom_range(0, 23));
          mi = MIN_W'($urandom_range(0, 59));
          s  = SEC_W'($urandom_range(0, 59));
        end else begin
          h  = HOUR_W'($urandom_range(0, 31));
          mi = MIN_W'($urandom_range(0, 63));
          s  = SEC_W'($urandom_range(0, 63));
        end
        word = pack_date(y, mo, d, h, mi, s);
      end else begin
        // noise: any bit pattern, mostly rejected
        word = IN_W'({$urandom, $urandom});
      end
      offer_date(word, 1'b0, typed, (n >= 300 && n < 360));
      if (n % 200 == 199) drain_epochs();
    end

    drain_epochs();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_epochs.size() != 0) begin
      mismatches++;
      $display("%0t: %0d expected results never arrived", $time, pending_epochs.size());
    end
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
